/* design/qrls_pkg.sv */
// Shared types and constants for the quantized row LUT scorer.
// Holds the transaction payload structs, opcodes, register indexes and store control.
// No dependencies.
package qrls_pkg;

    localparam int unsigned BLOCK_DIM   = 128;
    localparam int unsigned MAX_DIM_DEF = 512;

    localparam logic [1:0] OP_LUT_WR = 2'd0;
    localparam logic [1:0] OP_ROW_WR = 2'd1;
    localparam logic [1:0] OP_SCORE  = 2'd2;

    localparam logic [1:0] REG_CODE_BITS  = 2'd0;
    localparam logic [1:0] REG_DIM_BLOCKS = 2'd1;
    localparam logic [1:0] REG_LUT_SCALE  = 2'd2;
    localparam logic [1:0] REG_LUT_BIAS   = 2'd3;

    localparam logic [2:0]  CODE_BITS_RST  = 3'd4;
    localparam logic [2:0]  CODE_BITS_TWO  = 3'd2;
    localparam logic [2:0]  DIM_BLOCKS_RST = 3'd1;
    localparam logic [31:0] LUT_SCALE_RST  = 32'h0100_0000;
    localparam logic [31:0] LUT_BIAS_RST   = 32'h0000_0000;

    localparam logic [63:0] SCORE_MAX = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] SCORE_MIN = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [12:0]        address;
        logic [7:0]         data;
        logic signed [31:0] row_scale;
    } qrls_in_t;

    typedef struct packed {
        logic signed [63:0] score;
        logic               saturated;
    } qrls_out_t;

    typedef struct packed {
        logic       lut_we;
        logic       row_we;
        logic       lut_re;
        logic       row_re;
        logic [1:0] plane_sel;
    } qrls_mem_ctl_t;

endpackage

/* design/quantized_row_lut_scorer_top.sv */
// Quantized row LUT scorer, top level: handshake, configuration registers,
// score sequencer and the shared 32x32 multiplier. Depends on qrls_pkg and qrls_stores.
//
// A score runs a per-plane-byte loop of row reads then LUT reads through the single LUT read
// port over dim_blocks*16 row positions, capped at MAX_DIM/8; the final fixed-point scaling
// takes three passes through one shared 32x32 multiplier. The input is not ready while a
// score runs; a finished result waits in the output register and does not hold up the next
// transaction, though a later score waits in its output state until that result is taken.
module quantized_row_lut_scorer_top #(
    parameter int unsigned MAX_DIM = qrls_pkg::MAX_DIM_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  qrls_pkg::qrls_in_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output qrls_pkg::qrls_out_t m_data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_wdata
);
    import qrls_pkg::*;

    localparam int unsigned LUT_DEPTH = MAX_DIM * 16;
    localparam int unsigned ROW_DEPTH = MAX_DIM / 2;
    localparam int unsigned LUT_AW    = $clog2(LUT_DEPTH);
    localparam int unsigned ROW_AW    = $clog2(ROW_DEPTH);
    localparam int unsigned GRP_W     = LUT_AW - 5;
    localparam int unsigned MAX_NPOS  = MAX_DIM / 8;
    localparam int unsigned POS_W     = $clog2(MAX_NPOS + 1);
    localparam int unsigned SUM_W     = $clog2(MAX_DIM) + 7;
    localparam int unsigned ACC_W     = SUM_W + 33;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_ROW   = 4'd1;
    localparam logic [3:0] ST_LUT   = 4'd2;
    localparam logic [3:0] ST_DRAIN = 4'd3;
    localparam logic [3:0] ST_MUL1  = 4'd4;
    localparam logic [3:0] ST_ACC   = 4'd5;
    localparam logic [3:0] ST_ABS   = 4'd6;
    localparam logic [3:0] ST_MUL2  = 4'd7;
    localparam logic [3:0] ST_MUL3  = 4'd8;
    localparam logic [3:0] ST_RND   = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    logic [2:0]        code_bits_reg;
    logic [2:0]        dim_blocks_reg;
    logic [31:0]       lut_scale_reg;
    logic [31:0]       lut_bias_reg;

    logic [3:0]        state_reg, state_next;
    logic [1:0]        p_reg, p_next;
    logic [2:0]        h_reg, h_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [ROW_AW-1:0] base_reg, base_next;
    logic [GRP_W-1:0]  g_reg, g_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic              lut_cap_reg;
    logic [31:0]       rs_reg, rs_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [ACC_W-1:0]  a_reg, a_next;
    logic [31:0]       b_reg, b_next;
    logic              neg_reg, neg_next;
    logic [63:0]       lo_reg, lo_next;
    logic [63:0]       mul_p_reg;
    logic [63:0]       mag_reg, mag_next;
    logic              ovf_reg, ovf_next;
    logic              m_valid_reg, m_valid_next;
    qrls_out_t         m_data_reg, m_data_next;

    logic              accept;
    logic              use4;
    logic [31:0]       dimb16;
    logic [31:0]       npos32;
    logic [POS_W-1:0]  npos;
    logic [1:0]        last_p;
    logic [2:0]        last_h;
    logic [3:0]        nibble;
    logic [2:0]        c0, c1, bp;
    logic [31:0]       mul_a, mul_b;
    logic [6:0]        lut_rdata;
    logic [3:0][7:0]   planes;
    qrls_mem_ctl_t     mem_ctl;
    logic              sat;
    logic              load_out;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign use4    = (code_bits_reg != CODE_BITS_TWO);
    assign dimb16  = 32'(dim_blocks_reg) << 4;
    assign npos32  = (dimb16 > 32'(MAX_NPOS)) ? 32'(MAX_NPOS) : dimb16;
    assign npos    = npos32[POS_W-1:0];
    assign last_p  = use4 ? 2'd3 : 2'd1;
    assign last_h  = use4 ? 3'd7 : 3'd3;

    always_comb begin
        bp = ~h_reg;
        c0 = ~{h_reg[1:0], 1'b0};
        c1 = ~{h_reg[1:0], 1'b1};
        if (use4) begin
            nibble = {planes[3][bp], planes[2][bp], planes[1][bp], planes[0][bp]};
        end else begin
            nibble = {planes[1][c0], planes[0][c0], planes[1][c1], planes[0][c1]};
        end
    end

    always_comb begin
        mem_ctl.lut_we    = accept && (s_data.opcode == OP_LUT_WR)
                            && (32'(s_data.address) < 32'(LUT_DEPTH));
        mem_ctl.row_we    = accept && (s_data.opcode == OP_ROW_WR)
                            && (32'(s_data.address) < 32'(ROW_DEPTH));
        mem_ctl.lut_re    = (state_reg == ST_LUT);
        mem_ctl.row_re    = (state_reg == ST_ROW);
        mem_ctl.plane_sel = p_reg;
    end

    qrls_stores #(
        .MAX_DIM(MAX_DIM)
    ) u_stores (
        .aclk      (aclk),
        .ctl       (mem_ctl),
        .lut_waddr (LUT_AW'(s_data.address)),
        .lut_wdata (s_data.data[6:0]),
        .lut_raddr ({g_reg, h_reg[0], nibble}),
        .row_waddr (ROW_AW'(s_data.address)),
        .row_wdata (s_data.data),
        .row_raddr (base_reg + ROW_AW'(pos_reg)),
        .lut_rdata (lut_rdata),
        .planes    (planes)
    );

    always_comb begin
        case (state_reg)
            ST_MUL1: begin
                mul_a = lut_scale_reg;
                mul_b = 32'(sum_reg);
            end
            ST_MUL2: begin
                mul_a = a_reg[31:0];
                mul_b = b_reg;
            end
            default: begin
                mul_a = 32'(a_reg[ACC_W-1:32]);
                mul_b = b_reg;
            end
        endcase
    end

    assign sat      = ovf_reg || (neg_reg ? (mag_reg > SCORE_MIN) : mag_reg[63]);
    assign load_out = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next   = state_reg;
        p_next       = p_reg;
        h_next       = h_reg;
        pos_next     = pos_reg;
        base_next    = base_reg;
        g_next       = g_reg;
        sum_next     = lut_cap_reg ? (sum_reg + SUM_W'(lut_rdata)) : sum_reg;
        rs_next      = rs_reg;
        acc_next     = acc_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        neg_next     = neg_reg;
        lo_next      = lo_reg;
        mag_next     = mag_reg;
        ovf_next     = ovf_reg;
        m_valid_next = (m_valid_reg && !m_ready) || load_out;
        m_data_next  = m_data_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_data.opcode == OP_SCORE)) begin
                    rs_next   = s_data.row_scale;
                    sum_next  = '0;
                    pos_next  = '0;
                    p_next    = '0;
                    h_next    = '0;
                    base_next = '0;
                    g_next    = '0;
                    state_next = (npos == '0) ? ST_MUL1 : ST_ROW;
                end
            end
            ST_ROW: begin
                if (p_reg == last_p) begin
                    p_next     = '0;
                    base_next  = '0;
                    h_next     = '0;
                    state_next = ST_LUT;
                end else begin
                    p_next    = p_reg + 2'd1;
                    base_next = base_reg + ROW_AW'(npos);
                end
            end
            ST_LUT: begin
                if (h_reg[0]) begin
                    g_next = g_reg + GRP_W'(1);
                end
                if (h_reg == last_h) begin
                    if (pos_reg == npos - POS_W'(1)) begin
                        state_next = ST_DRAIN;
                    end else begin
                        pos_next   = pos_reg + POS_W'(1);
                        state_next = ST_ROW;
                    end
                end else begin
                    h_next = h_reg + 3'd1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                state_next = ST_ACC;
            end
            ST_ACC: begin
                acc_next = {{(ACC_W-40){lut_bias_reg[31]}}, lut_bias_reg, 8'd0}
                           + ACC_W'(mul_p_reg);
                state_next = ST_ABS;
            end
            ST_ABS: begin
                a_next     = acc_reg[ACC_W-1] ? (~acc_reg + ACC_W'(1)) : acc_reg;
                b_next     = rs_reg[31] ? (~rs_reg + 32'd1) : rs_reg;
                neg_next   = acc_reg[ACC_W-1] ^ rs_reg[31];
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                state_next = ST_MUL3;
            end
            ST_MUL3: begin
                lo_next    = mul_p_reg;
                state_next = ST_RND;
            end
            ST_RND: begin
                ovf_next   = |mul_p_reg[63:39];
                mag_next   = {mul_p_reg[39:0], 24'd0} + ((lo_reg + 64'd128) >> 8);
                neg_next   = neg_reg && (a_reg != '0) && (b_reg != '0);
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (load_out) begin
                    m_data_next.saturated = sat;
                    if (sat) begin
                        m_data_next.score = neg_reg ? SCORE_MIN : SCORE_MAX;
                    end else begin
                        m_data_next.score = neg_reg ? (~mag_reg + 64'd1) : mag_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            lut_cap_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
            code_bits_reg  <= CODE_BITS_RST;
            dim_blocks_reg <= DIM_BLOCKS_RST;
            lut_scale_reg  <= LUT_SCALE_RST;
            lut_bias_reg   <= LUT_BIAS_RST;
            p_reg          <= '0;
            h_reg          <= '0;
            pos_reg        <= '0;
            base_reg       <= '0;
            g_reg          <= '0;
        end else begin
            state_reg   <= state_next;
            lut_cap_reg <= (state_reg == ST_LUT);
            m_valid_reg <= m_valid_next;
            p_reg       <= p_next;
            h_reg       <= h_next;
            pos_reg     <= pos_next;
            base_reg    <= base_next;
            g_reg       <= g_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_CODE_BITS:  code_bits_reg  <= cfg_wdata[2:0];
                    REG_DIM_BLOCKS: dim_blocks_reg <= cfg_wdata[2:0];
                    REG_LUT_SCALE:  lut_scale_reg  <= cfg_wdata;
                    REG_LUT_BIAS:   lut_bias_reg   <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg    <= sum_next;
        rs_reg     <= rs_next;
        acc_reg    <= acc_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        neg_reg    <= neg_next;
        lo_reg     <= lo_next;
        mag_reg    <= mag_next;
        ovf_reg    <= ovf_next;
        mul_p_reg  <= 64'(mul_a) * 64'(mul_b);
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* design/qrls_stores.sv */
// LUT store and bit-plane row store with registered read ports.
// Row reads land in one of four plane byte registers; LUT reads in one data register.
// Depends on qrls_pkg.
module qrls_stores #(
    parameter int unsigned MAX_DIM = qrls_pkg::MAX_DIM_DEF,
    localparam int unsigned LUT_AW = $clog2(MAX_DIM * 16),
    localparam int unsigned ROW_AW = $clog2(MAX_DIM / 2)
) (
    input  logic                    aclk,
    input  qrls_pkg::qrls_mem_ctl_t ctl,
    input  logic [LUT_AW-1:0]       lut_waddr,
    input  logic [6:0]              lut_wdata,
    input  logic [LUT_AW-1:0]       lut_raddr,
    input  logic [ROW_AW-1:0]       row_waddr,
    input  logic [7:0]              row_wdata,
    input  logic [ROW_AW-1:0]       row_raddr,
    output logic [6:0]              lut_rdata,
    output logic [3:0][7:0]         planes
);
    import qrls_pkg::*;

    localparam int unsigned LUT_DEPTH = MAX_DIM * 16;
    localparam int unsigned ROW_DEPTH = MAX_DIM / 2;

    logic [6:0]     lut_mem [LUT_DEPTH];
    logic [7:0]     row_mem [ROW_DEPTH];
    logic [6:0]     lut_q_reg;
    logic [3:0][7:0] plane_reg;

    always_ff @(posedge aclk) begin
        if (ctl.lut_we) begin
            lut_mem[lut_waddr] <= lut_wdata;
        end
        if (ctl.lut_re) begin
            lut_q_reg <= lut_mem[lut_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.row_we) begin
            row_mem[row_waddr] <= row_wdata;
        end
        if (ctl.row_re) begin
            plane_reg[ctl.plane_sel] <= row_mem[row_raddr];
        end
    end

    assign lut_rdata = lut_q_reg;
    assign planes    = plane_reg;

endmodule
